FILE: hdl/ctp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time functions for the
// Cartesian to polar / cylindrical converter. No dependencies.
package ctp_pkg;

    localparam int DP_W     = 64;   // CORDIC datapath width
    localparam int ANG_W    = 32;   // binary angle width, 2^31 = pi
    localparam int DATA_W   = 32;   // z / height / radius width
    localparam int ATAN_LEN = 48;

    localparam logic [ANG_W-1:0] ANGLE_PI = 32'h8000_0000;

    // round(atan(2^-i) * 2^31 / pi)
    localparam logic [ANG_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000
    };

    // Sideband that travels with each request through the pipeline.
    typedef struct packed {
        logic                     origin;   // x = y = 0
        logic signed [DATA_W-1:0] height;
    } ctp_side_t;

    // CORDIC gain squared, prod(1 + 2^-2i), in Q60.
    function automatic logic [DP_W-1:0] gain_product(input int stages);
        logic [DP_W-1:0] p;
        p = 64'd1 << 60;
        for (int i = 0; i < ATAN_LEN; i++) begin
            if (i < stages && 2 * i < 64)
            begin
                p = p + (p >> (2 * i));
            end
        end
        return p;
    endfunction

    // Integer square root, one result bit per step.
    function automatic logic [DP_W-1:0] isqrt64(input logic [DP_W-1:0] v_in);
        logic [DP_W-1:0] v;
        logic [DP_W-1:0] res;
        logic [DP_W-1:0] bitv;
        v    = v_in;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

endpackage

FILE: hdl/cartesian_to_polar_cylindrical.sv
`timescale 1ns / 1ps
// Cartesian to polar / cylindrical converter, top level.
// Depends on ctp_pkg, ctp_cordic and ctp_scale.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one point per request:
//   coord_x, coord_y (signed Q16.16) and coord_z. Output channel
//   (out_valid / out_stall) returns radius (unsigned Q16.16, rounded),
//   angle (binary angle, 2^31 = pi) and height.
//   The pipeline has one entry stage, one stage per CORDIC
//   micro-rotation and three scaling stages. Throughput is one point per
//   clock while no held result stalls it; every stage is a register and the
//   whole pipeline advances together.
//   When the receiver stalls while a result is held, the whole pipeline
//   freezes and in_stall is raised in the same cycle; nothing is dropped
//   or repeated. Bubbles are not squeezed out, so new requests wait until
//   the held result is taken.
//   The third_axis_on register (cfg_wr_en / cfg_wr_data) selects
//   cylindrical mode (z copied to height) or planar mode (height 0);
//   write it only while the pipeline is empty. Reset sets it to 1 and
//   clears all valid bits; payload registers are not reset.
module cartesian_to_polar_cylindrical #(
    parameter int COORD_WIDTH   = 32,
    parameter int CORDIC_STAGES = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    // request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [COORD_WIDTH-1:0]   coord_x,
    input  logic signed [COORD_WIDTH-1:0]   coord_y,
    input  logic signed [ctp_pkg::DATA_W-1:0] coord_z,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ctp_pkg::DATA_W-1:0]      radius,
    output logic signed [ctp_pkg::ANG_W-1:0]  angle,
    output logic signed [ctp_pkg::DATA_W-1:0] height
);

    localparam int GUARD_BITS = 61 - COORD_WIDTH;
    localparam int EXT_W      = ctp_pkg::DP_W - COORD_WIDTH;

    logic third_axis_on_reg;
    logic adv;

    // entry stage signals
    logic signed [ctp_pkg::DP_W-1:0] x_ext, y_ext;
    logic                            x_neg;
    logic signed [ctp_pkg::DP_W-1:0] x0_next, x0_reg;
    logic signed [ctp_pkg::DP_W-1:0] y0_next, y0_reg;
    logic [ctp_pkg::ANG_W-1:0]       ang0_next, ang0_reg;
    ctp_pkg::ctp_side_t              side0_next, side0_reg;
    logic                            vld0_reg;

    // CORDIC to scaling
    logic                            cor_valid;
    logic signed [ctp_pkg::DP_W-1:0] cor_x;
    logic [ctp_pkg::ANG_W-1:0]       cor_ang;
    ctp_pkg::ctp_side_t              cor_side;

    // Advance everything unless a finished result is held by the receiver.
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            third_axis_on_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            third_axis_on_reg <= cfg_wr_data;
        end
    end

    // Entry stage: fold the left half plane onto the right one (angle
    // starts at pi), scale up into the guard bits, flag the origin.
    always_comb
    begin
        x_ext = {{EXT_W{coord_x[COORD_WIDTH-1]}}, coord_x};
        y_ext = {{EXT_W{coord_y[COORD_WIDTH-1]}}, coord_y};
        x_neg = x_ext[ctp_pkg::DP_W-1];
        if (x_neg)
        begin
            x0_next   = (64'sd0 - x_ext) <<< GUARD_BITS;
            y0_next   = (64'sd0 - y_ext) <<< GUARD_BITS;
            ang0_next = ctp_pkg::ANGLE_PI;
        end
        else
        begin
            x0_next   = x_ext <<< GUARD_BITS;
            y0_next   = y_ext <<< GUARD_BITS;
            ang0_next = '0;
        end
        side0_next.origin = (coord_x == '0) && (coord_y == '0);
        side0_next.height = third_axis_on_reg ? coord_z : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg    <= x0_next;
            y0_reg    <= y0_next;
            ang0_reg  <= ang0_next;
            side0_reg <= side0_next;
        end
    end

    // A bubble enters whenever no request is offered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld0_reg <= in_valid;
        end
    end

    ctp_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (vld0_reg),
        .x_in      (x0_reg),
        .y_in      (y0_reg),
        .ang_in    (ang0_reg),
        .side_in   (side0_reg),
        .valid_out (cor_valid),
        .x_out     (cor_x),
        .ang_out   (cor_ang),
        .side_out  (cor_side)
    );

    ctp_scale #(
        .COORD_WIDTH   (COORD_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (cor_valid),
        .x_in      (cor_x),
        .ang_in    (cor_ang),
        .side_in   (cor_side),
        .valid_out (out_valid),
        .radius    (radius),
        .angle     (angle),
        .height    (height)
    );

endmodule

FILE: hdl/ctp_cordic.sv
`timescale 1ns / 1ps
// Vectoring CORDIC: one register stage per micro-rotation.
// Depends on ctp_pkg.
module ctp_cordic #(
    parameter int STAGES = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          valid_in,
    input  logic signed [ctp_pkg::DP_W-1:0]  x_in,
    input  logic signed [ctp_pkg::DP_W-1:0]  y_in,
    input  logic [ctp_pkg::ANG_W-1:0]     ang_in,
    input  ctp_pkg::ctp_side_t            side_in,
    output logic                          valid_out,
    output logic signed [ctp_pkg::DP_W-1:0]  x_out,
    output logic [ctp_pkg::ANG_W-1:0]     ang_out,
    output ctp_pkg::ctp_side_t            side_out
);

    logic signed [ctp_pkg::DP_W-1:0] x_w   [STAGES+1];
    logic signed [ctp_pkg::DP_W-1:0] y_w   [STAGES];
    logic [ctp_pkg::ANG_W-1:0]       ang_w [STAGES+1];
    ctp_pkg::ctp_side_t              side_w[STAGES+1];
    logic                            vld_w [STAGES+1];

    assign x_w[0]    = x_in;
    assign y_w[0]    = y_in;
    assign ang_w[0]  = ang_in;
    assign side_w[0] = side_in;
    assign vld_w[0]  = valid_in;

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [ctp_pkg::DP_W-1:0] x_next;
        logic signed [ctp_pkg::DP_W-1:0] x_reg;
        logic [ctp_pkg::ANG_W-1:0]       ang_next;
        logic [ctp_pkg::ANG_W-1:0]       ang_reg;
        ctp_pkg::ctp_side_t              side_reg;
        logic                            vld_reg;

        // rotate toward the x axis: sign of y picks the direction
        always_comb
        begin
            if (!y_w[i][ctp_pkg::DP_W-1])
            begin
                x_next   = x_w[i] + (y_w[i] >>> i);
                ang_next = ang_w[i] + ctp_pkg::ATAN_TABLE[i];
            end
            else
            begin
                x_next   = x_w[i] - (y_w[i] >>> i);
                ang_next = ang_w[i] - ctp_pkg::ATAN_TABLE[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg    <= x_next;
                ang_reg  <= ang_next;
                side_reg <= side_w[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg <= vld_w[i];
            end
        end

        // the last stage has no use for y
        if (i < STAGES - 1) begin : g_y
            logic signed [ctp_pkg::DP_W-1:0] y_next;
            logic signed [ctp_pkg::DP_W-1:0] y_reg;

            always_comb
            begin
                if (!y_w[i][ctp_pkg::DP_W-1])
                begin
                    y_next = y_w[i] - (x_w[i] >>> i);
                end
                else
                begin
                    y_next = y_w[i] + (x_w[i] >>> i);
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    y_reg <= y_next;
                end
            end

            assign y_w[i+1] = y_reg;
        end

        assign x_w[i+1]    = x_reg;
        assign ang_w[i+1]  = ang_reg;
        assign side_w[i+1] = side_reg;
        assign vld_w[i+1]  = vld_reg;
    end

    assign valid_out = vld_w[STAGES];
    assign x_out     = x_w[STAGES];
    assign ang_out   = ang_w[STAGES];
    assign side_out  = side_w[STAGES];

endmodule

FILE: hdl/ctp_scale.sv
`timescale 1ns / 1ps
// Gain correction, rounding and saturation of the CORDIC magnitude;
// three register stages, the last one is the output register. Depends on ctp_pkg.
module ctp_scale #(
    parameter int COORD_WIDTH   = 32,
    parameter int CORDIC_STAGES = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          valid_in,
    input  logic signed [ctp_pkg::DP_W-1:0]  x_in,
    input  logic [ctp_pkg::ANG_W-1:0]     ang_in,
    input  ctp_pkg::ctp_side_t            side_in,
    output logic                          valid_out,
    output logic [ctp_pkg::DATA_W-1:0]    radius,
    output logic signed [ctp_pkg::ANG_W-1:0]  angle,
    output logic signed [ctp_pkg::DATA_W-1:0] height
);

    localparam int GUARD_BITS = 61 - COORD_WIDTH;
    localparam logic [ctp_pkg::DP_W-1:0] GAIN_S =
        ctp_pkg::isqrt64(ctp_pkg::gain_product(CORDIC_STAGES));
    localparam logic [ctp_pkg::DP_W-1:0] INV_K_FULL =
        ((64'd1 << 62) + (GAIN_S >> 1)) / GAIN_S;
    localparam logic [31:0] INV_K = INV_K_FULL[31:0];
    localparam logic [ctp_pkg::DP_W-1:0] HALF_LSB = 64'd1 << (GUARD_BITS - 1);

    // stage 1: clamp and split multiply
    logic [ctp_pkg::DP_W-1:0] x_pos;
    logic [ctp_pkg::DP_W-1:0] prod_hi_next, prod_hi_reg;
    logic [ctp_pkg::DP_W-1:0] prod_lo_next, prod_lo_reg;
    logic [ctp_pkg::ANG_W-1:0] ang1_reg;
    ctp_pkg::ctp_side_t       side1_reg;
    logic                     vld1_reg;

    // stage 2: partial product sum
    logic [ctp_pkg::DP_W-1:0] t_next, t_reg;
    logic [ctp_pkg::ANG_W-1:0] ang2_reg;
    ctp_pkg::ctp_side_t       side2_reg;
    logic                     vld2_reg;

    // stage 3: round, saturate, output register
    logic [ctp_pkg::DP_W-1:0]    rounded;
    logic [ctp_pkg::DP_W-1:0]    shifted;
    logic [ctp_pkg::DATA_W-1:0]  radius_next, radius_reg;
    logic [ctp_pkg::ANG_W-1:0]   angle_next, angle_reg;
    logic [ctp_pkg::DATA_W-1:0]  height_reg;
    logic                        vld3_reg;

    always_comb
    begin
        x_pos        = x_in[ctp_pkg::DP_W-1] ? '0 : x_in;
        prod_hi_next = 64'(x_pos[63:32]) * 64'(INV_K);
        prod_lo_next = 64'(x_pos[31:0]) * 64'(INV_K);
    end

    always_comb
    begin
        t_next = prod_hi_reg + (prod_lo_reg >> 32);
    end

    always_comb
    begin
        rounded = t_reg + HALF_LSB;
        shifted = rounded >> GUARD_BITS;
        if (side2_reg.origin)
        begin
            radius_next = '0;
            angle_next  = '0;
        end
        else
        begin
            radius_next = (shifted[63:32] != '0) ? '1 : shifted[31:0];
            angle_next  = ang2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_hi_reg <= prod_hi_next;
            prod_lo_reg <= prod_lo_next;
            ang1_reg    <= ang_in;
            side1_reg   <= side_in;
            t_reg       <= t_next;
            ang2_reg    <= ang1_reg;
            side2_reg   <= side1_reg;
            radius_reg  <= radius_next;
            angle_reg   <= angle_next;
            height_reg  <= side2_reg.height;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld1_reg <= valid_in;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    assign valid_out = vld3_reg;
    assign radius    = radius_reg;
    assign angle     = angle_reg;
    assign height    = height_reg;

endmodule

FILE: hdl/ctp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the converter, bound to the top level.
// Depends on ctp_pkg and cartesian_to_polar_cylindrical.
module ctp_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic signed [COORD_WIDTH-1:0]   coord_x,
    input logic signed [COORD_WIDTH-1:0]   coord_y,
    input logic signed [ctp_pkg::DATA_W-1:0] coord_z,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [ctp_pkg::DATA_W-1:0]      radius,
    input logic signed [ctp_pkg::ANG_W-1:0]  angle,
    input logic signed [ctp_pkg::DATA_W-1:0] height
);

    // hold a stalled request unchanged
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(coord_x)
            && $stable(coord_y) && $stable(coord_z))
        else $error("stalled request changed");

    // hold a stalled result unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(radius)
            && $stable(angle) && $stable(height))
        else $error("stalled result changed");

    // stall the requester exactly when a held result blocks the pipeline
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("in_stall does not follow output backpressure");

    // drop all results on reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

endmodule

bind cartesian_to_polar_cylindrical ctp_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_ctp_checker (.*);

FILE: sim/tb_cartesian_to_polar_cylindrical.sv
`timescale 1ns / 1ps
// Self-checking testbench for cartesian_to_polar_cylindrical: drives points
// with random gaps, predicts radius/angle/height and checks every result.
// Depends on ctp_pkg and the converter RTL.
module tb_cartesian_to_polar_cylindrical;

    localparam int CW          = 32;
    localparam int STAGES      = 32;
    localparam int GUARD       = 61 - CW;
    localparam int LATENCY     = STAGES + 4;
    localparam int IDLE_LIMIT  = 5000;   // cycles with no handshake on either side
    localparam int HOLD_CYCLES = 400;    // long receiver back-pressure stretch
    localparam int PHASE_ITEMS = 200;
    localparam int PHASES      = 5;

    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic [31:0] MAX_POS   = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_NEG   = 32'h8000_0000;
    localparam logic [31:0] ONE_Q16   = 32'h0001_0000;

    // one converted point as it appears on the result channel
    typedef struct packed {
        logic [31:0] radius;
        logic [31:0] angle;
        logic [31:0] height;
    } polar_t;

    // Keeps the mode copy, predicts each accepted point and holds the
    // predictions in arrival order until the matching result shows up.
    class polar_tracker;
        logic [31:0] arctan_step [STAGES];
        logic [63:0] inv_gain;
        bit          axis3;
        polar_t      awaited [$];
        int          errors;

        function new();
            logic [63:0] gain_sq;
            logic [63:0] root;
            logic [63:0] cand;
            arctan_step = '{
                32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
                32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
                32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
            };
            axis3  = 1'b1;
            errors = 0;
            // squared gain in Q60, truncating each partial product
            gain_sq = 64'd1 << 60;
            for (int i = 0; i < STAGES; i++)
            begin
                if (2 * i < 64)
                begin
                    gain_sq = gain_sq + (gain_sq >> (2 * i));
                end
            end
            // floor square root, one bit at a time from the top
            root = '0;
            for (int b = 31; b >= 0; b--)
            begin
                cand = root | (64'd1 << b);
                if (cand * cand <= gain_sq)
                begin
                    root = cand;
                end
            end
            inv_gain = ((64'd1 << 62) + (root >> 1)) / root;
        endfunction

        function polar_t to_polar(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
            logic [63:0] vx;
            logic [63:0] vy;
            logic [63:0] sx;
            logic [63:0] sy;
            logic [63:0] acc;
            logic [63:0] mag;
            logic [31:0] ang;
            polar_t      res;
            vx  = {{32{cx[31]}}, cx};
            vy  = {{32{cy[31]}}, cy};
            ang = '0;
            mag = '0;
            if (vx != 0 || vy != 0)
            begin
                // fold the left half-plane onto the right one
                if (vx[63])
                begin
                    vx  = -vx;
                    vy  = -vy;
                    ang = HALF_TURN;
                end
                vx = vx << GUARD;
                vy = vy << GUARD;
                for (int i = 0; i < STAGES; i++)
                begin
                    sx = $signed(vx) >>> i;
                    sy = $signed(vy) >>> i;
                    if (!vy[63])
                    begin
                        vx  = vx + sy;
                        vy  = vy - sx;
                        ang = ang + arctan_step[i];
                    end
                    else
                    begin
                        vx  = vx - sy;
                        vy  = vy + sx;
                        ang = ang - arctan_step[i];
                    end
                end
                if (vx[63])
                begin
                    vx = '0;
                end
                acc = (vx >> 32) * inv_gain + (((vx & 64'hFFFF_FFFF) * inv_gain) >> 32);
                mag = (acc + (64'd1 << (GUARD - 1))) >> GUARD;
                if (mag > 64'hFFFF_FFFF)
                begin
                    mag = 64'hFFFF_FFFF;
                end
            end
            res.radius = mag[31:0];
            res.angle  = ang;
            res.height = axis3 ? cz : '0;
            return res;
        endfunction

        function void note_point(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
            awaited.push_back(to_polar(cx, cy, cz));
        endfunction

        task report(string msg);
            if (errors < 40)
            begin
                $display("[%0t] MISMATCH %s", $time, msg);
            end
            errors++;
        endtask

        task check_polar(polar_t got);
            polar_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result r=%h a=%h h=%h",
                                 got.radius, got.angle, got.height));
            end
            else
            begin
                want = awaited.pop_front();
                if (got.radius !== want.radius)
                begin
                    report($sformatf("radius %h, want %h", got.radius, want.radius));
                end
                if (got.angle !== want.angle)
                begin
                    report($sformatf("angle %h, want %h", got.angle, want.angle));
                end
                if (got.height !== want.height)
                begin
                    report($sformatf("height %h, want %h", got.height, want.height));
                end
            end
        endtask
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic                     cfg_wr_data;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [CW-1:0]     coord_x;
    logic signed [CW-1:0]     coord_y;
    logic signed [31:0]       coord_z;
    logic                     out_valid;
    logic                     out_stall;
    logic [31:0]              radius;
    logic signed [31:0]       angle;
    logic signed [31:0]       height;

    polar_tracker tracker;
    int           sent_count;
    int           taken_count;
    int           quiet_cycles;

    cartesian_to_polar_cylindrical #(
        .COORD_WIDTH   (CW),
        .CORDIC_STAGES (STAGES)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .radius      (radius),
        .angle       (angle),
        .height      (height)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Idle draw shared by both sides: every third stretch of 40 items runs
    // back to back, the rest wait a randomly drawn gap before each item.
    function automatic int draw_gap(int n);
        if ((n / 40) % 3 == 0)
        begin
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // Offer one point, hold it steady until the converter takes it, then
    // record the prediction. Valid stays high into the next request when
    // no gap is drawn.
    task send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        int gap;
        gap = draw_gap(sent_count);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        coord_x  <= px;
        coord_y  <= py;
        coord_z  <= pz;
        @(posedge clk);
        while (!(in_valid && !in_stall))
        begin
            @(posedge clk);
        end
        tracker.note_point(px, py, pz);
        sent_count++;
    endtask

    // Mix of shapes: full-range noise, small magnitudes of either sign,
    // points on an axis or a diagonal, the origin and the corner values.
    task pick_point(output logic [31:0] px, output logic [31:0] py, output logic [31:0] pz);
        int          kind;
        int          sa;
        int          sb;
        logic [31:0] corner [5];
        corner = '{MIN_NEG, MAX_POS, 32'h0, 32'hFFFF_FFFF, 32'h1};
        kind   = $urandom_range(0, 9);
        px     = $urandom();
        py     = $urandom();
        pz     = $urandom();
        sa     = $urandom();
        sb     = $urandom();
        case (kind)
            3, 4:
            begin
                px = sa >>> $urandom_range(0, 31);
                py = sb >>> $urandom_range(0, 31);
            end
            5:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    px = '0;
                end
                else
                begin
                    py = '0;
                end
            end
            6:
            begin
                py = $urandom_range(0, 1) ? px : -px;
            end
            7:
            begin
                px = (sa >>> 28);
                py = (sb >>> 28);
            end
            8:
            begin
                px = corner[$urandom_range(0, 4)];
                py = corner[$urandom_range(0, 4)];
            end
            default:
            begin
            end
        endcase
    endtask

    // Drain the pipeline, pause, then write the mode register.
    task write_axis_mode(bit on);
        while (tracker.awaited.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= on;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tracker.axis3 = on;
    endtask

    // Result side: stall for a drawn number of cycles, then take one
    // result and check it. Twice in the run, hold off for a long stretch
    // so the pipeline fills and pushes back on the request side.
    initial
    begin
        int     hold;
        polar_t got;
        out_stall   <= 1'b1;
        taken_count = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = draw_gap(taken_count + 20);
            if (taken_count == 150 || taken_count == 700)
            begin
                hold = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall))
            begin
                @(posedge clk);
            end
            got.radius = radius;
            got.angle  = angle;
            got.height = height;
            tracker.check_polar(got);
            taken_count++;
        end
    end

    // Watchdog: end the run if neither side moves for too long.
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("tb_cartesian_to_polar_cylindrical: errors");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed corners in the reset mode, then
    // random phases alternating planar and cylindrical mode.
    initial
    begin
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        tracker     = new();
        sent_count  = 0;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        in_valid    <= 1'b0;
        coord_x     <= '0;
        coord_y     <= '0;
        coord_z     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: origin, unit axes, the negative axis (half turn),
        // field extremes and a few easy radii
        send_point(32'h0, 32'h0, MAX_POS);
        send_point(32'h1, 32'h0, MIN_NEG);
        send_point(32'h0, 32'h1, 32'h0);
        send_point(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        send_point(32'h0, 32'hFFFF_FFFF, 32'h1);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678);
        send_point(MAX_POS, MAX_POS, 32'h5555_5555);
        send_point(MIN_NEG, MIN_NEG, 32'hAAAA_AAAA);
        send_point(MIN_NEG, 32'h0, 32'h0);
        send_point(32'h0, MIN_NEG, 32'h0);
        send_point(MAX_POS, 32'h0, 32'h0);
        send_point(32'h0, MAX_POS, 32'h0);
        send_point(MIN_NEG, MAX_POS, 32'h0);
        send_point(MAX_POS, MIN_NEG, 32'h0);
        send_point(ONE_Q16, ONE_Q16, 32'h0);
        send_point(3 * ONE_Q16, 4 * ONE_Q16, 32'h0);
        send_point(-3 * ONE_Q16, 4 * ONE_Q16, 32'h0);
        send_point(-3 * ONE_Q16, -4 * ONE_Q16, 32'h0);
        send_point(MIN_NEG, 32'h1, MIN_NEG);
        send_point(MIN_NEG, 32'hFFFF_FFFF, MAX_POS);
        in_valid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_axis_mode(ph % 2 == 1);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                pick_point(px, py, pz);
                send_point(px, py, pz);
            end
            in_valid <= 1'b0;
        end

        // wait for the last results, then let the pipeline run empty
        while (tracker.awaited.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 8) @(posedge clk);
        if (tracker.awaited.size() != 0)
        begin
            tracker.report($sformatf("%0d results never arrived", tracker.awaited.size()));
        end
        if (tracker.errors == 0)
        begin
            $display("tb_cartesian_to_polar_cylindrical: clean");
        end
        else
        begin
            $display("tb_cartesian_to_polar_cylindrical: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/ctp_pkg.sv
hdl/ctp_cordic.sv
hdl/ctp_scale.sv
hdl/cartesian_to_polar_cylindrical.sv
hdl/ctp_checker.sv
sim/tb_cartesian_to_polar_cylindrical.sv
